### rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// shared types and constants of the signed integer to radix text block
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int NUM_W          = 32;
    localparam int CHAR_W         = 8;
    localparam int MAX_RADIX      = 16;
    localparam int DIGIT_W        = $clog2(MAX_RADIX);
    localparam int RADIX_W        = 5;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 2;
    localparam int ALPHA_W        = MAX_RADIX * CHAR_W;
    localparam int STACK_DEPTH    = NUM_W;
    localparam int STACK_IDX_W    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W        = STACK_IDX_W + 1;
    localparam int BITS_PER_STEP  = 8;
    localparam int STEPS_PER_DIG  = NUM_W / BITS_PER_STEP;
    localparam int STEP_W         = $clog2(STEPS_PER_DIG);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load_number;
        logic div_step;
        logic load_sign;
        logic load_digit;
    } cmd_t;

    typedef struct packed {
        logic alphabet_ok;
        logic div_done;
        logic negative;
        logic depth_one;
        logic out_free;
    } status_t;

endpackage

### rtl/sirt_ctrl.sv
// ----------------------------------------------------------------------------
// sirt_ctrl
// sequencer: alphabet check, digit loop, then sign and digit emission
// ----------------------------------------------------------------------------
module sirt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sirt_pkg::status_t  status,
    output sirt_pkg::cmd_t     cmd
);

    sirt_pkg::state_t state_reg;
    sirt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sirt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            sirt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_number = 1'b1;
                    state_next      = sirt_pkg::ST_CHECK;
                end
            end
            sirt_pkg::ST_CHECK:
            begin
                // bad alphabet: drop the word, nothing is emitted
                if (status.alphabet_ok)
                begin
                    state_next = sirt_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = sirt_pkg::ST_IDLE;
                end
            end
            sirt_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = status.negative ? sirt_pkg::ST_SIGN
                                                 : sirt_pkg::ST_DIGITS;
                end
            end
            sirt_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = sirt_pkg::ST_DIGITS;
                end
            end
            sirt_pkg::ST_DIGITS:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (status.depth_one)
                    begin
                        state_next = sirt_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sirt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sirt_datapath.sv
// ----------------------------------------------------------------------------
// sirt_datapath
// config registers, alphabet check, digit divider, digit stack, output word
// ----------------------------------------------------------------------------
module sirt_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sirt_pkg::CFG_W-1:0]         cfg_data,
    input  logic [sirt_pkg::NUM_W-1:0]         number,
    input  sirt_pkg::cmd_t                     cmd,
    output sirt_pkg::status_t                  status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_last
);

    // configuration
    logic [sirt_pkg::RADIX_W-1:0]   radix_reg;
    logic [sirt_pkg::CFG_W-1:0]     alpha_low_reg;
    logic [sirt_pkg::CFG_W-1:0]     alpha_high_reg;
    logic [sirt_pkg::ALPHA_W-1:0]   alphabet;

    // divider and digit stack
    logic [sirt_pkg::NUM_W-1:0]     work_reg;
    logic [sirt_pkg::NUM_W-1:0]     work_next;
    logic [sirt_pkg::DIGIT_W-1:0]   rem_reg;
    logic [sirt_pkg::DIGIT_W-1:0]   rem_next;
    logic [sirt_pkg::STEP_W-1:0]    step_reg;
    logic                           neg_reg;
    logic [sirt_pkg::DIGIT_W-1:0]   stack_reg [sirt_pkg::STACK_DEPTH];
    logic [sirt_pkg::DEPTH_W-1:0]   depth_reg;
    logic [sirt_pkg::DEPTH_W-1:0]   depth_dec;
    logic [sirt_pkg::DIGIT_W-1:0]   top_digit;
    logic                           last_step;

    // output word
    logic                           out_valid_reg;
    logic [sirt_pkg::CHAR_W-1:0]    out_char_reg;
    logic                           out_last_reg;

    logic                           alpha_ok;
    logic [sirt_pkg::BITS_PER_STEP-1:0] qbits;

    assign alphabet = {alpha_high_reg, alpha_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sirt_pkg::REG_RADIX)
            begin
                radix_reg <= cfg_data[sirt_pkg::RADIX_W-1:0];
            end
            if (cfg_index == sirt_pkg::REG_ALPHA_LOW)
            begin
                alpha_low_reg <= cfg_data;
            end
            if (cfg_index == sirt_pkg::REG_ALPHA_HIGH)
            begin
                alpha_high_reg <= cfg_data;
            end
        end
    end

    // alphabet check: radix range, reserved bytes and pairwise duplicates among used digits
    always_comb
    begin
        logic [sirt_pkg::CHAR_W-1:0] ci;
        alpha_ok = (radix_reg >= sirt_pkg::RADIX_W'(2))
                && (radix_reg <= sirt_pkg::RADIX_W'(sirt_pkg::MAX_RADIX));
        for (int i = 0; i < sirt_pkg::MAX_RADIX; i++)
        begin
            ci = alphabet[i*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
            if (sirt_pkg::RADIX_W'(i) < radix_reg)
            begin
                if (ci == '0 || ci == sirt_pkg::CHAR_PLUS || ci == sirt_pkg::CHAR_MINUS)
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sirt_pkg::MAX_RADIX; j++)
                begin
                    if (sirt_pkg::RADIX_W'(j) < radix_reg
                        && alphabet[j*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W] == ci)
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // one slice of restoring division: eight quotient bits per cycle
    always_comb
    begin
        logic [sirt_pkg::DIGIT_W:0]   t;
        logic [sirt_pkg::DIGIT_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < sirt_pkg::BITS_PER_STEP; i++)
        begin
            t = {r, work_reg[sirt_pkg::NUM_W-1-i]};
            if (t >= radix_reg)
            begin
                qbits[sirt_pkg::BITS_PER_STEP-1-i] = 1'b1;
                r = sirt_pkg::DIGIT_W'(t - radix_reg);
            end
            else
            begin
                r = t[sirt_pkg::DIGIT_W-1:0];
            end
        end
        rem_next  = r;
        work_next = {work_reg[sirt_pkg::NUM_W-sirt_pkg::BITS_PER_STEP-1:0], qbits};
    end

    assign last_step = (step_reg == sirt_pkg::STEP_W'(sirt_pkg::STEPS_PER_DIG - 1));
    assign depth_dec = depth_reg - sirt_pkg::DEPTH_W'(1);
    assign top_digit = stack_reg[depth_dec[sirt_pkg::STACK_IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            depth_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else if (cmd.load_number)
        begin
            step_reg  <= '0;
            depth_reg <= '0;
            neg_reg   <= number[sirt_pkg::NUM_W-1];
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + sirt_pkg::STEP_W'(1);
            if (last_step)
            begin
                depth_reg <= depth_reg + sirt_pkg::DEPTH_W'(1);
            end
        end
        else if (cmd.load_digit)
        begin
            depth_reg <= depth_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_number)
        begin
            // magnitude as unsigned, so the most negative value is exact
            work_reg <= number[sirt_pkg::NUM_W-1] ? (~number + sirt_pkg::NUM_W'(1)) : number;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            work_reg <= work_next;
            if (last_step)
            begin
                rem_reg <= '0;
                stack_reg[depth_reg[sirt_pkg::STACK_IDX_W-1:0]] <= rem_next;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_sign || cmd.load_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sign)
        begin
            out_char_reg <= sirt_pkg::CHAR_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            out_char_reg <= alphabet[top_digit*sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
            out_last_reg <= (depth_reg == sirt_pkg::DEPTH_W'(1));
        end
    end

    assign status.alphabet_ok = alpha_ok;
    assign status.div_done    = last_step && (work_next == '0);
    assign status.negative    = neg_reg;
    assign status.depth_one   = (depth_reg == sirt_pkg::DEPTH_W'(1));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

### rtl/signed_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// prints a signed 32-bit number as text in a configured radix and alphabet
// ----------------------------------------------------------------------------
// sequence: the word is taken, the alphabet is checked, then the divider
//   makes D digits, D = number of digits (1 to 32), resolving 8 quotient bits a cycle;
// output: the sign if negative, then the digits, through the single output
//   register, one character a cycle while the output is not stalled
// reset: rst_n clears radix and alphabet to zero (invalid alphabet), the
//   sequencer to idle and the output word to empty
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration writes: 0 radix, 1 alphabet_low, 2 alphabet_high
    input  logic                            cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sirt_pkg::CFG_W-1:0]      cfg_data,

    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sirt_pkg::NUM_W-1:0]      s_tdata,    // [31:0] number

    // output words, one character each
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sirt_pkg::CHAR_W-1:0]     m_tdata,    // [7:0] character
    output logic                            m_tlast     // last character of the text
);

    sirt_pkg::cmd_t    cmd;
    sirt_pkg::status_t status;

    // sequencer: takes a word only when idle; the output register lets the
    // next word start while the final character still waits downstream
    sirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: config, alphabet check, iterative divider, digit stack and
    // output register; digits come out least significant first and are
    // popped from the stack so the text goes most significant first
    sirt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### tb/sv/sirt_text_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sirt_text_scoreboard_pkg
// predicts the text of each accepted number and checks the characters
// ----------------------------------------------------------------------------
package sirt_text_scoreboard_pkg;

    import sirt_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    class sirt_text_scoreboard;

        logic [RADIX_W-1:0] radix    = '0;
        logic [CFG_W-1:0]   alpha_lo = '0;
        logic [CFG_W-1:0]   alpha_hi = '0;

        text_char_t pending_text [$];

        int mismatches     = 0;
        int numbers_taken  = 0;
        int numbers_silent = 0;
        int chars_checked  = 0;
        int finals_checked = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                REG_RADIX:      radix    = value[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_lo = value;
                REG_ALPHA_HIGH: alpha_hi = value;
                default:        ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] digit_glyph(logic [DIGIT_W-1:0] digit);
            logic [CFG_W-1:0] half;
            half = digit[3] ? alpha_hi : alpha_lo;
            return half[digit[2:0]*CHAR_W +: CHAR_W];
        endfunction

        function bit alphabet_valid();
            logic [CHAR_W-1:0] glyph;
            if (radix < 2 || radix > MAX_RADIX)
                return 1'b0;
            for (int i = 0; i < radix; i++)
            begin
                glyph = digit_glyph(DIGIT_W'(i));
                if (glyph == '0 || glyph == CHAR_PLUS || glyph == CHAR_MINUS)
                    return 1'b0;
                for (int j = i + 1; j < radix; j++)
                    if (digit_glyph(DIGIT_W'(j)) == glyph)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        // text of one number: sign, then digits of the unsigned magnitude
        function void note_number(logic [NUM_W-1:0] number);
            logic [NUM_W-1:0]   magnitude;
            logic [DIGIT_W-1:0] digits [NUM_W];
            int                 count;
            numbers_taken++;
            if (!alphabet_valid())
            begin
                numbers_silent++;
                return;
            end
            magnitude = number[NUM_W-1] ? NUM_W'(0) - number : number;
            count = 0;
            do
            begin
                digits[count] = DIGIT_W'(magnitude % NUM_W'(radix));
                magnitude     = magnitude / NUM_W'(radix);
                count++;
            end
            while (magnitude != 0 && count < NUM_W);
            if (number[NUM_W-1])
                pending_text.push_back(text_char_t'{CHAR_MINUS, 1'b0});
            for (int k = count - 1; k >= 0; k--)
                pending_text.push_back(text_char_t'{digit_glyph(digits[k]), k == 0});
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last);
            text_char_t want;
            chars_checked++;
            if (last)
                finals_checked++;
            if (pending_text.size() == 0)
            begin
                $error("unexpected word: character %h last %b", character, last);
                mismatches++;
                return;
            end
            want = pending_text.pop_front();
            if (character !== want.character)
            begin
                $error("character mismatch: expected %h, actual %h",
                       want.character, character);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %b, actual %b", want.last, last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_text.size();
        endfunction

    endclass

endpackage

### tb/sv/signed_integer_to_radix_text_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_tb
// self-checking bench for the signed number to radix text converter
// ----------------------------------------------------------------------------
// numbers go in on the input stream, characters come back on the output
// stream; a scoreboard predicts each number's text from its own copy of the
// radix and alphabet registers and checks every character in order. a short
// directed part hits the extremes, zero, the most negative value, every kind
// of broken alphabet and the ignored register index; then random alphabets
// and random numbers with random stalls on both sides
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_tb;

    import sirt_pkg::*;
    import sirt_text_scoreboard_pkg::*;

    // register index with no register behind it, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // worst word: 32 digits plus sign through the divider, with margin
    localparam int SETTLE_CYCLES  = 200;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 20;

    typedef enum int {
        FLAW_RADIX_LOW,
        FLAW_RADIX_HIGH,
        FLAW_REPEAT,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_ZERO
    } flaw_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [NUM_W-1:0]   s_tdata   = '0;    // [31:0] number
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;           // [7:0] character
    logic               m_tlast;

    sirt_text_scoreboard text_board = new();

    // knobs shared by the stimulus and the output side
    bit tx_idle   = 1'b1;
    bit rx_idle   = 1'b1;
    bit long_hold = 1'b0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    signed_integer_to_radix_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // output side: check every accepted word, stall in random bursts, and
    // once hold off long enough for the block to back up into its input
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                text_board.check_char(m_tdata, m_tlast);
            if (long_hold)
            begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: too long with nothing moving on any port means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one register write; cfg_we stays high so writes can go back to back
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        text_board.write_reg(index, value);
    endtask

    task automatic cfg_done();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_alphabet(input logic [CFG_W-1:0] radix_word,
                                input logic [CFG_W-1:0] lo,
                                input logic [CFG_W-1:0] hi);
        cfg_write(REG_RADIX, radix_word);
        cfg_write(REG_ALPHA_LOW, lo);
        cfg_write(REG_ALPHA_HIGH, hi);
        cfg_done();
        settings_used++;
    endtask

    // offer one number, with an optional random gap ahead of it
    task automatic send_number(input logic [NUM_W-1:0] value);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        text_board.note_number(value);
    endtask

    // stop offering until every predicted character has come back
    task automatic drain_text();
        s_tvalid <= 1'b0;
        while (text_board.outstanding() != 0) @(posedge clk);
    endtask

    // registers only change with the block idle; a number under a broken
    // alphabet leaves nothing to wait for, so give it the full latency
    task automatic settle_block();
        drain_text();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void put_glyph(input int idx, input logic [CHAR_W-1:0] glyph,
                                      inout logic [CFG_W-1:0] lo, inout logic [CFG_W-1:0] hi);
        if (idx < 8)
            lo[idx*CHAR_W +: CHAR_W] = glyph;
        else
            hi[(idx-8)*CHAR_W +: CHAR_W] = glyph;
    endfunction

    // distinct usable glyphs in the first r slots, noise in the rest
    function automatic void make_alphabet(input int r, output logic [CFG_W-1:0] lo,
                                          output logic [CFG_W-1:0] hi);
        bit                used [256];
        logic [CHAR_W-1:0] glyph;
        lo = {$urandom(), $urandom()};
        hi = {$urandom(), $urandom()};
        for (int i = 0; i < r; i++)
        begin
            do
                glyph = CHAR_W'($urandom_range(1, 255));
            while (used[glyph] || glyph == CHAR_PLUS || glyph == CHAR_MINUS);
            used[glyph] = 1'b1;
            put_glyph(i, glyph, lo, hi);
        end
    endfunction

    // mix of full range, small values, extremes, powers of two, short widths
    function automatic logic [NUM_W-1:0] random_number();
        logic [NUM_W-1:0] value;
        case ($urandom_range(0, 5))
            0: value = $urandom();
            1: value = NUM_W'($urandom_range(0, 40));
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'h0000_0000;
                    3:       value = 32'hFFFF_FFFF;
                    default: value = 32'h0000_0001;
                endcase
            end
            3: value = (NUM_W'(1) << $urandom_range(0, 31)) - NUM_W'($urandom_range(0, 1));
            default: value = $urandom() >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 2) == 0)
            value = -value;
        return value;
    endfunction

    // write an alphabet that breaks one rule, then push numbers that must
    // produce no text at all
    task automatic run_broken_alphabet(input flaw_t kind, input int count);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        int               r;
        int               i;
        int               j;
        logic [CHAR_W-1:0] glyph;
        r = $urandom_range(2, MAX_RADIX);
        make_alphabet(r, lo, hi);
        i = $urandom_range(0, r - 1);
        case (kind)
            FLAW_RADIX_LOW:  r = $urandom_range(0, 1);
            FLAW_RADIX_HIGH: r = $urandom_range(MAX_RADIX + 1, 31);
            FLAW_REPEAT:
            begin
                do
                    j = $urandom_range(0, r - 1);
                while (j == i);
                glyph = (j < 8) ? lo[j*CHAR_W +: CHAR_W] : hi[(j-8)*CHAR_W +: CHAR_W];
                put_glyph(i, glyph, lo, hi);
            end
            FLAW_PLUS:  put_glyph(i, CHAR_PLUS, lo, hi);
            FLAW_MINUS: put_glyph(i, CHAR_MINUS, lo, hi);
            default:    put_glyph(i, '0, lo, hi);
        endcase
        settle_block();
        set_alphabet({$urandom(), $urandom() & ~32'h1F | r}, lo, hi);
        repeat (count) send_number(random_number());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        int               r;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset the radix is zero, so these give no text
        send_number(32'd0);
        send_number(-32'sd5);

        // binary, unused slots hold plus, minus and zero bytes which must not matter
        settle_block();
        set_alphabet(64'd2, 64'h2B2D_0000_2D2B_3130, 64'h0);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'h0000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'h0000_0001);
        send_number(32'hAAAA_AAAA);
        send_number(32'h5555_5555);

        // full hex alphabet, digits 8 and up come from the high register
        settle_block();
        set_alphabet(64'd16, "76543210", "FEDCBA98");
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'hDEAD_BEEF);
        send_number(32'h0000_000F);
        send_number(32'h0000_0010);
        send_number(-32'sd16);

        // write to the unused index must leave the alphabet alone
        settle_block();
        cfg_write(REG_UNUSED, {$urandom(), $urandom()});
        cfg_done();
        send_number(32'h0123_4567);

        // decimal, radix written with junk above its five bits
        settle_block();
        set_alphabet(64'hFFFF_FFFF_FFFF_FFEA, "76543210", 64'h0000_0000_0000_3938);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'hFFFF_FFFF);
        send_number(32'd10);
        send_number(32'd0);

        // radix three with glyphs at the byte extremes
        settle_block();
        set_alphabet(64'd3, 64'h0000_0000_0001_80FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(32'h8000_0000);
        send_number(32'd12345);

        // every way an alphabet can be broken
        for (int k = FLAW_RADIX_LOW; k <= FLAW_ZERO; k++)
            run_broken_alphabet(flaw_t'(k), 1);

        // random alphabets and numbers; no idling in the last two phases
        for (int p = 0; p < PHASES; p++)
        begin
            if (p % 3 == 2)
                run_broken_alphabet(flaw_t'($urandom_range(FLAW_RADIX_LOW, FLAW_ZERO)), 3);
            case (p)
                0:       r = 2;
                1:       r = MAX_RADIX;
                2:       r = 3;
                default: r = $urandom_range(2, MAX_RADIX);
            endcase
            make_alphabet(r, lo, hi);
            settle_block();
            set_alphabet({$urandom(), $urandom() & ~32'h1F | r}, lo, hi);
            if (p >= PHASES - 2)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            // output held off while the sender keeps offering
            if (p == 2)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pauses until all text is back, then resumes
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain_text();
                send_number(random_number());
            end
        end

        settle_block();

        $display("converted %0d numbers (%0d under broken alphabets) across %0d settings",
                 text_board.numbers_taken, text_board.numbers_silent, settings_used);
        $display("checked %0d characters ending %0d texts",
                 text_board.chars_checked, text_board.finals_checked);
        if (text_board.mismatches == 0 && text_board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### signed_integer_to_radix_text.f
rtl/sirt_pkg.sv
rtl/sirt_ctrl.sv
rtl/sirt_datapath.sv
rtl/signed_integer_to_radix_text.sv
tb/sv/sirt_text_scoreboard_pkg.sv
tb/sv/signed_integer_to_radix_text_tb.sv
